// ----- sv/lmhg_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lmhg_pkg - shared types and constants of the max-height grid
// Payload structs, RAM word layout, action codes, sequencer states and the
// fixed constants of the intensity shading.
// ---------------------------------------------------------------------------
package lmhg_pkg;

  // grid size defaults
  localparam int ROWS_DEF = 512;
  localparam int COLS_DEF = 512;

  // configuration
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int CELL_W  = 10;
  localparam logic [CELL_W-1:0] CELL_RESET = 10'd10;
  localparam logic [CELL_W-1:0] CELL_MIN   = 10'd1;
  localparam logic [CELL_W-1:0] CELL_MAX   = 10'd1000;

  // action codes
  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_POINT = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic signed [15:0] LOWEST_RESET = 16'sd32767;

  // centre coordinate saturation bounds
  localparam int COORD_MAX = 524287;
  localparam int COORD_MIN = -524288;

  // shading: q = (n + 20) / 40 with n = (h + 300) * 17, saturated to 0..255
  localparam logic signed [16:0] SHADE_OFS   = 17'sd300;
  localparam logic signed [21:0] SHADE_BIAS  = 22'sd20;
  localparam logic signed [21:0] SHADE_SAT_N = 22'sd10220;
  localparam logic [11:0]        RECIP5      = 12'd3277;  // 2^14 / 5, rounded up
  localparam int                 RECIP_SH    = 14;

  typedef struct packed {
    logic [1:0]          action;
    logic signed [15:0]  x_cm;
    logic signed [15:0]  y_cm;
    logic signed [15:0]  z_cm;
    logic [8:0]          read_row;
    logic [8:0]          read_col;
  } in_item_t;

  typedef struct packed {
    logic                in_range;
    logic                occupied;
    logic signed [15:0]  height_cm;
    logic [7:0]          intensity;
    logic signed [19:0]  cell_x_cm;
    logic signed [19:0]  cell_y_cm;
    logic signed [15:0]  lowest_cm;
  } out_item_t;

  // one grid cell as held in the RAM
  typedef struct packed {
    logic                occ;
    logic signed [15:0]  height;
  } cell_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_NUM,
    ST_CHK,
    ST_DIV,
    ST_CX,
    ST_CY,
    ST_ADDR,
    ST_RD,
    ST_USE,
    ST_SHADE,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- sv/lmhg_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lmhg_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module lmhg_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 262144
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/lidar_max_height_grid.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lidar_max_height_grid - bird's-eye maximum-height map
// Bins points into a ROWS x COLS grid, keeps the highest z per cell and the
// running lowest non-maximum height; reports cells on request.
// ---------------------------------------------------------------------------
// Accept to strobe: a point runs MUL, NUM, CHK, DIV per axis, then ADDR, RD and USE, or
// leaves at CHK off the grid; a read runs CX, CY, ADDR, RD, USE and SHADE;
// frame and spare go to OUT. Busy falls the cycle after the strobe but for a frame;
// points are paced by the shared restoring divider (one quotient bit a cycle, run
// once per axis). A frame beat is followed by a clearing sweep; reset starts the same
// sweep, config writes are taken meanwhile. Results cannot be stalled: one cycle each.
module lidar_max_height_grid #(
  parameter int ROWS = lmhg_pkg::ROWS_DEF,
  parameter int COLS = lmhg_pkg::COLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          start,
  output      logic                          busy,
  input  wire lmhg_pkg::in_item_t            in_data,
  // result channel
  output      logic                          out_strobe,
  output      lmhg_pkg::out_item_t           out_data,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lmhg_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [lmhg_pkg::CFG_DW-1:0]   pwdata,
  output      logic [lmhg_pkg::CFG_DW-1:0]   prdata,
  output      logic                          pready
);

  localparam int NMAX   = (ROWS > COLS) ? ROWS : COLS;
  localparam int DEPTH  = ROWS * COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);
  localparam int QW     = $clog2(NMAX);
  localparam int STEP_W = $clog2(QW + 1);
  localparam int NB_W   = $clog2(NMAX + 1);
  localparam int MA_W   = ((NB_W > 10) ? NB_W : 10) + 1;
  localparam int MB_W   = lmhg_pkg::CELL_W + 1;
  localparam int P_W    = MA_W + MB_W;
  localparam int NUM_W  = P_W + 1;
  localparam int WORD_W = $bits(lmhg_pkg::cell_word_t);

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [P_W-1:0] C_MAX = P_W'(lmhg_pkg::COORD_MAX);
  localparam logic signed [P_W-1:0] C_MIN = P_W'(lmhg_pkg::COORD_MIN);

  // control registers
  lmhg_pkg::state_t             state_r, state_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic signed [15:0]           lowest_r, lowest_nxt;
  logic [lmhg_pkg::CELL_W-1:0]  cell_cfg_r, cell_cfg_nxt;

  // payload registers
  lmhg_pkg::in_item_t           item_r, item_nxt;
  logic [lmhg_pkg::CELL_W-1:0]  cell_r, cell_nxt;
  logic signed [P_W-1:0]        prod_r, prod_nxt;
  logic signed [NUM_W-1:0]      rem_r, rem_nxt;
  logic signed [NUM_W-1:0]      lim_r, lim_nxt;
  logic signed [NUM_W-1:0]      dsh_r, dsh_nxt;
  logic [QW-1:0]                q_r, q_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         axis_r, axis_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic [CW-1:0]                col_r, col_nxt;
  logic                         grid_ok_r, grid_ok_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic signed [21:0]           n_r, n_nxt;
  lmhg_pkg::out_item_t          res_r, res_nxt;

  // shared multiplier
  logic signed [MA_W-1:0]       mul_a;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [P_W-1:0]        mul_res;

  // datapath helpers
  logic                         accept;
  logic                         cfg_we;
  logic [lmhg_pkg::CELL_W-1:0]  cell_clamp;
  logic [MB_W-1:0]              den;
  logic signed [NUM_W-1:0]      trial;
  logic                         chk_ok;
  logic signed [15:0]           v_sel;
  logic signed [16:0]           hs;
  logic [10:0]                  shade_k;
  logic [22:0]                  shade_p;
  logic signed [21:0]           n_bias;

  // RAM port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  lmhg_pkg::cell_word_t         ram_wdata;
  logic                         ram_re;
  lmhg_pkg::cell_word_t         ram_rdata;

  function automatic logic signed [19:0] sat_coord(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] h;
    h = p >>> 1;  // floor of half
    if (h > C_MAX) begin
      h = C_MAX;
    end else if (h < C_MIN) begin
      h = C_MIN;
    end
    return h[19:0];
  endfunction

  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && !paddr[2];

  assign cell_clamp = (cell_cfg_r < lmhg_pkg::CELL_MIN) ? lmhg_pkg::CELL_MIN :
                      (cell_cfg_r > lmhg_pkg::CELL_MAX) ? lmhg_pkg::CELL_MAX : cell_cfg_r;

  assign den     = {cell_r, 1'b0};
  assign trial   = rem_r - dsh_r;
  assign chk_ok  = !rem_r[NUM_W-1] && (rem_r < lim_r);
  assign v_sel   = axis_r ? item_r.y_cm : item_r.x_cm;
  assign hs      = 17'(ram_rdata.height) + lmhg_pkg::SHADE_OFS;
  assign n_bias  = n_r + lmhg_pkg::SHADE_BIAS;
  assign shade_k = n_bias[13:3];
  assign shade_p = 23'(shade_k) * 23'(lmhg_pkg::RECIP5);

  always_comb begin
    unique case (state_r)
      lmhg_pkg::ST_MUL: mul_a = axis_r ? MA_W'(COLS) : MA_W'(ROWS);
      lmhg_pkg::ST_CX:  mul_a = MA_W'(ROWS) - MA_W'({item_r.read_row, 1'b0});
      lmhg_pkg::ST_CY:  mul_a = MA_W'(COLS) - MA_W'({item_r.read_col, 1'b0});
      default:          mul_a = '0;
    endcase
  end

  assign mul_b   = {1'b0, cell_r};
  assign mul_res = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lmhg_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) state_nxt = lmhg_pkg::ST_IDLE;
      end
      lmhg_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data.action)
            lmhg_pkg::ACT_POINT: state_nxt = lmhg_pkg::ST_MUL;
            lmhg_pkg::ACT_READ:  state_nxt = lmhg_pkg::ST_CX;
            default:             state_nxt = lmhg_pkg::ST_OUT;
          endcase
        end
      end
      lmhg_pkg::ST_MUL:   state_nxt = lmhg_pkg::ST_NUM;
      lmhg_pkg::ST_NUM:   state_nxt = lmhg_pkg::ST_CHK;
      lmhg_pkg::ST_CHK:   state_nxt = chk_ok ? lmhg_pkg::ST_DIV : lmhg_pkg::ST_OUT;
      lmhg_pkg::ST_DIV: begin
        if (step_r == '0) state_nxt = axis_r ? lmhg_pkg::ST_ADDR : lmhg_pkg::ST_MUL;
      end
      lmhg_pkg::ST_CX:    state_nxt = lmhg_pkg::ST_CY;
      lmhg_pkg::ST_CY:    state_nxt = lmhg_pkg::ST_ADDR;
      lmhg_pkg::ST_ADDR:  state_nxt = lmhg_pkg::ST_RD;
      lmhg_pkg::ST_RD:    state_nxt = lmhg_pkg::ST_USE;
      lmhg_pkg::ST_USE: begin
        state_nxt = (item_r.action == lmhg_pkg::ACT_READ) ? lmhg_pkg::ST_SHADE
                                                           : lmhg_pkg::ST_OUT;
      end
      lmhg_pkg::ST_SHADE: state_nxt = lmhg_pkg::ST_OUT;
      lmhg_pkg::ST_OUT: begin
        state_nxt = (item_r.action == lmhg_pkg::ACT_FRAME) ? lmhg_pkg::ST_CLEAR
                                                            : lmhg_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    lowest_nxt   = lowest_r;
    cell_cfg_nxt = cfg_we ? pwdata[lmhg_pkg::CELL_W-1:0] : cell_cfg_r;
    item_nxt     = item_r;
    cell_nxt     = cell_r;
    prod_nxt     = prod_r;
    rem_nxt      = rem_r;
    lim_nxt      = lim_r;
    dsh_nxt      = dsh_r;
    q_nxt        = q_r;
    step_nxt     = step_r;
    axis_nxt     = axis_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    grid_ok_nxt  = grid_ok_r;
    addr_nxt     = addr_r;
    n_nxt        = n_r;
    res_nxt      = res_r;
    unique case (state_r)
      lmhg_pkg::ST_CLEAR: clr_cnt_nxt = clr_cnt_r + AW'(1);
      lmhg_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt    = in_data;
          cell_nxt    = cell_clamp;
          res_nxt     = '0;
          axis_nxt    = 1'b0;
          row_nxt     = RW'(in_data.read_row);
          col_nxt     = CW'(in_data.read_col);
          grid_ok_nxt = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLS);
          if (in_data.action == lmhg_pkg::ACT_FRAME) lowest_nxt = lmhg_pkg::LOWEST_RESET;
        end
      end
      lmhg_pkg::ST_MUL: prod_nxt = mul_res;
      lmhg_pkg::ST_NUM: begin
        // numerator N*cell - 2v over divisor 2*cell
        rem_nxt = NUM_W'(prod_r) - (NUM_W'(v_sel) <<< 1);
        lim_nxt = NUM_W'(prod_r) <<< 1;
      end
      lmhg_pkg::ST_CHK: begin
        dsh_nxt  = NUM_W'(den) << (QW - 1);
        q_nxt    = '0;
        step_nxt = STEP_W'(QW - 1);
      end
      lmhg_pkg::ST_DIV: begin
        if (!trial[NUM_W-1]) rem_nxt = trial;
        q_nxt    = QW'({q_r, !trial[NUM_W-1]});
        dsh_nxt  = dsh_r >>> 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          if (!axis_r) begin
            row_nxt  = RW'(q_nxt);
            axis_nxt = 1'b1;
          end else begin
            col_nxt          = CW'(q_nxt);
            grid_ok_nxt      = 1'b1;
            res_nxt.in_range = 1'b1;
          end
        end
      end
      lmhg_pkg::ST_CX: prod_nxt = mul_res;
      lmhg_pkg::ST_CY: begin
        res_nxt.cell_x_cm = sat_coord(prod_r);
        prod_nxt          = mul_res;
      end
      lmhg_pkg::ST_ADDR: begin
        if (item_r.action == lmhg_pkg::ACT_READ) res_nxt.cell_y_cm = sat_coord(prod_r);
        addr_nxt = AW'(AW'(row_r) * AW'(COLS) + AW'(col_r));
      end
      lmhg_pkg::ST_RD: begin
      end
      lmhg_pkg::ST_USE: begin
        if (item_r.action == lmhg_pkg::ACT_POINT) begin
          // equal height is not a new maximum
          if (ram_rdata.occ && (item_r.z_cm <= ram_rdata.height) &&
              (item_r.z_cm < lowest_r)) begin
            lowest_nxt = item_r.z_cm;
          end
        end else if (grid_ok_r && ram_rdata.occ) begin
          res_nxt.occupied  = 1'b1;
          res_nxt.height_cm = ram_rdata.height;
          n_nxt             = (22'(hs) <<< 4) + 22'(hs);
        end
      end
      lmhg_pkg::ST_SHADE: begin
        if (res_r.occupied) begin
          if (n_r[21]) begin
            res_nxt.intensity = 8'd0;
          end else if (n_r >= lmhg_pkg::SHADE_SAT_N) begin
            res_nxt.intensity = 8'd255;
          end else begin
            res_nxt.intensity = shade_p[lmhg_pkg::RECIP_SH +: 8];
          end
        end
      end
      lmhg_pkg::ST_OUT: begin
        if (item_r.action == lmhg_pkg::ACT_FRAME) clr_cnt_nxt = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy       = (state_r != lmhg_pkg::ST_IDLE);
    out_strobe = (state_r == lmhg_pkg::ST_OUT);
    out_data           = res_r;
    out_data.lowest_cm = lowest_r;
    pready     = 1'b1;
    prdata     = paddr[2] ? '0 : lmhg_pkg::CFG_DW'(cell_cfg_r);
    ram_we     = 1'b0;
    ram_waddr  = addr_r;
    ram_wdata  = '0;
    ram_re     = (state_r == lmhg_pkg::ST_RD) &&
                 (grid_ok_r || (item_r.action == lmhg_pkg::ACT_POINT));
    unique case (state_r)
      lmhg_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      lmhg_pkg::ST_USE: begin
        if ((item_r.action == lmhg_pkg::ACT_POINT) &&
            (!ram_rdata.occ || (item_r.z_cm > ram_rdata.height))) begin
          ram_we           = 1'b1;
          ram_wdata.occ    = 1'b1;
          ram_wdata.height = item_r.z_cm;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lmhg_pkg::ST_CLEAR;
      clr_cnt_r  <= '0;
      lowest_r   <= lmhg_pkg::LOWEST_RESET;
      cell_cfg_r <= lmhg_pkg::CELL_RESET;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      lowest_r   <= lowest_nxt;
      cell_cfg_r <= cell_cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    cell_r    <= cell_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    lim_r     <= lim_nxt;
    dsh_r     <= dsh_nxt;
    q_r       <= q_nxt;
    step_r    <= step_nxt;
    axis_r    <= axis_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    grid_ok_r <= grid_ok_nxt;
    addr_r    <= addr_nxt;
    n_r       <= n_nxt;
    res_r     <= res_nxt;
  end

  lmhg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ----- sv/lmhg_check.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lmhg_check - port-level assertions for the max-height grid
// Watches the command, result and reset behaviour seen at the top level.
// ---------------------------------------------------------------------------
module lmhg_check (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_strobe,
  input wire lmhg_pkg::out_item_t         out_data
);

  // reset always leads into the clearing sweep
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy ##1 !out_strobe)
    else $error("result beat outside busy or longer than one cycle");

  a_empty_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.occupied) |->
      (out_data.height_cm == 16'sd0) && (out_data.intensity == 8'd0))
    else $error("empty cell reports a height");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_data.in_range && out_data.occupied))
    else $error("point and read flags both set");

endmodule

bind lidar_max_height_grid lmhg_check u_lmhg_check (.*);
`default_nettype wire
